[hw/rtl/segstk_pkg.sv]
// Shared types and constants for the segmented stack with pop-at.
// Used by segstk_cell and segmented_stack_with_pop_at_core; no dependencies.
package segstk_pkg;

	localparam int DEF_TOTAL_DEPTH = 64;
	localparam int DEF_DATA_WIDTH  = 32;

	localparam int VAL_W  = 32;  // push_value / popped_value width
	localparam int KIDX_W = 6;   // substack_index width
	localparam int CAP_W  = 7;   // sub_capacity register width
	localparam int PROD_W = KIDX_W + CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3);

	// group size of the first level of the tap OR tree
	localparam int GRP_SIZE = 8;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_POP_AT = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_BADIDX = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_CALC,
		SEQ_GATHER,
		SEQ_APPLY
	} seq_state_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic load;   // take the broadcast push data
		logic shift;  // take the upper neighbor's data
		logic sel;    // drive the stored entry onto the tap
	} cell_ctrl_t;

endpackage

[hw/rtl/segmented_stack_with_pop_at_core.sv]
// Top level of the segmented stack with pop-at: sequencer, chain of cells, tap OR tree.
// Depends on segstk_pkg and segstk_cell.
//
// A bounded LIFO of TOTAL_DEPTH entries, viewed as sub-stacks of sub_capacity
// entries each (a capacity of zero acts as one). Entries stay contiguous, so
// every sub-stack but the last is full. Push appends at the top, pop removes
// the top, and pop-at on sub-stack k removes entry k*capacity+capacity-1 (or
// the top entry if the last sub-stack is only partly full); every entry above
// it moves down one cell at once through the neighbor links of the
// cell chain. Each item yields exactly one result carrying the removed value,
// a status (ok, empty, bad index with value all ones, full with the push
// dropped) and the entry count after the operation. An item passes through
// these steps in order: latching it, the sub-stack address (a small multiply
// of index by capacity and a compare against the fill count), a gather of the
// addressed cell through a registered OR tree in groups of eight cells, and
// the update of the cells with the load of the result register. The input
// stays closed until the update is done, so an item is not accepted while
// the one before it is still in progress. The next item is accepted while a
// result waits in the output register; the update stage holds only when that
// register is still full, and the input stays closed for as long as it holds.
// The configuration register is written with cfg_wr_en and takes effect for
// the next item. Storage has no reset; entries above the fill count are
// never read, so no clearing pass is needed.
module segmented_stack_with_pop_at_core
	import segstk_pkg::*;
#(
	parameter int TOTAL_DEPTH = DEF_TOTAL_DEPTH,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
	localparam int CW = $clog2(TOTAL_DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         cfg_wr_data,
	// input items
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic signed [VAL_W-1:0]  push_value,
	input  logic [KIDX_W-1:0]        substack_index,
	// result items
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VAL_W-1:0]  popped_value,
	output logic [1:0]               status,
	output logic [CW-1:0]            entry_count
);

	localparam int IW = (TOTAL_DEPTH > 1) ? $clog2(TOTAL_DEPTH) : 1;
	localparam int NG = (TOTAL_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
	localparam int PW = ((CW > PROD_W) ? CW : PROD_W) + 1;

	seq_state_t state_q, state_d;

	logic [CAP_W-1:0]      cap_q;
	logic [CW-1:0]         fill_q;

	// latched item
	opcode_t               op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [KIDX_W-1:0]     k_q;

	// decoded operation
	status_t               st_q;
	logic                  ld_q;
	logic                  rm_q;
	logic [IW-1:0]         pos_q;

	// result register
	logic                  out_valid_q;
	logic [VAL_W-1:0]      popped_q;
	status_t               status_q;
	logic [CW-1:0]         count_q;

	logic                  accept;
	logic                  apply_go;

	assign in_ready = (state_q == SEQ_IDLE);
	assign accept   = in_valid && in_ready;
	assign apply_go = (state_q == SEQ_APPLY) && (!out_valid_q || out_ready);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE:   if (accept) state_d = SEQ_CALC;
			SEQ_CALC:   state_d = SEQ_GATHER;
			SEQ_GATHER: state_d = SEQ_APPLY;
			SEQ_APPLY:  if (apply_go) state_d = SEQ_IDLE;
			default:    state_d = SEQ_IDLE;
		endcase
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// ---------------- latch the item ----------------
	logic [63:0] push_ext;
	assign push_ext = 64'(push_value);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode_t'(opcode);
			val_q <= push_ext[DATA_WIDTH-1:0];
			k_q   <= substack_index;
		end
	end

	// ---------------- address calculation ----------------
	logic [CAP_W-1:0] cap_eff;
	logic [PW-1:0]    prod;
	logic [PW-1:0]    pos_sub;
	logic [PW-1:0]    last_pos;
	logic [PW-1:0]    pos_pick;
	logic             fill_empty;
	logic             fill_full;
	logic             bad_idx;
	status_t          st_d;
	logic             ld_d;
	logic             rm_d;
	logic [PW-1:0]    pos_d;

	always_comb begin
		cap_eff    = (cap_q == '0) ? CAP_W'(1) : cap_q;
		prod       = PW'(k_q) * PW'(cap_eff);
		pos_sub    = prod + PW'(cap_eff) - PW'(1);
		last_pos   = PW'(fill_q) - PW'(1);
		fill_empty = (fill_q == '0);
		fill_full  = (fill_q == CW'(TOTAL_DEPTH));
		// k is in range exactly when k*capacity lies below the fill count
		bad_idx    = (prod >= PW'(fill_q));
		pos_pick   = (pos_sub > last_pos) ? last_pos : pos_sub;

		st_d  = STAT_OK;
		ld_d  = 1'b0;
		rm_d  = 1'b0;
		pos_d = last_pos;
		unique case (op_q)
			OP_PUSH: begin
				if (fill_full) st_d = STAT_FULL;
				else ld_d = 1'b1;
			end
			OP_POP: begin
				if (fill_empty) st_d = STAT_EMPTY;
				else rm_d = 1'b1;
			end
			OP_POP_AT: begin
				if (fill_empty) begin
					st_d = STAT_EMPTY;
				end else if (bad_idx) begin
					st_d = STAT_BADIDX;
				end else begin
					rm_d  = 1'b1;
					pos_d = pos_pick;
				end
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_CALC) begin
			st_q  <= st_d;
			ld_q  <= ld_d;
			rm_q  <= rm_d;
			pos_q <= pos_d[IW-1:0];
		end
	end

	// ---------------- chain of cells ----------------
	cell_ctrl_t            ctrl [TOTAL_DEPTH];
	logic [DATA_WIDTH-1:0] cell_q [TOTAL_DEPTH];
	logic [DATA_WIDTH-1:0] taps [TOTAL_DEPTH];
	logic [IW-1:0]         fill_idx;

	assign fill_idx = fill_q[IW-1:0];

	for (genvar i = 0; i < TOTAL_DEPTH; i++) begin : g_cell
		localparam logic [IW-1:0] MY_IDX = IW'(i);
		logic [DATA_WIDTH-1:0] upper;

		if (i == TOTAL_DEPTH - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = cell_q[i+1];
		end

		// cells at and above the removed slot take their neighbor's entry
		assign ctrl[i].load  = apply_go && ld_q && (fill_idx == MY_IDX);
		assign ctrl[i].shift = apply_go && rm_q && (pos_q <= MY_IDX);
		assign ctrl[i].sel   = (pos_q == MY_IDX);

		segstk_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl[i]),
			.wr_data  (val_q),
			.next_data(upper),
			.data_q   (cell_q[i]),
			.tap      (taps[i])
		);
	end

	// ---------------- tap gather ----------------
	logic [DATA_WIDTH-1:0] grp_or [NG];
	logic [DATA_WIDTH-1:0] grp_q [NG];
	logic [DATA_WIDTH-1:0] gathered;

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_or[g] = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (g * GRP_SIZE + j < TOTAL_DEPTH) begin
					grp_or[g] = grp_or[g] | taps[g * GRP_SIZE + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_GATHER) begin
			for (int g = 0; g < NG; g++) begin
				grp_q[g] <= grp_or[g];
			end
		end
	end

	always_comb begin
		gathered = '0;
		for (int g = 0; g < NG; g++) begin
			gathered = gathered | grp_q[g];
		end
	end

	// ---------------- apply and result ----------------
	logic [63:0]   gathered_ext;
	logic [CW-1:0] fill_d;

	assign gathered_ext = 64'(signed'(gathered));

	always_comb begin
		priority if (ld_q) begin
			fill_d = fill_q + CW'(1);
		end else if (rm_q) begin
			fill_d = fill_q - CW'(1);
		end else begin
			fill_d = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply_go) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			status_q <= st_q;
			count_q  <= fill_d;
			priority if (rm_q) begin
				popped_q <= gathered_ext[VAL_W-1:0];
			end else if (st_q == STAT_BADIDX) begin
				popped_q <= '1;
			end else begin
				popped_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = signed'(popped_q);
	assign status       = status_q;
	assign entry_count  = count_q;

	// ---------------- assertions ----------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TOTAL_DEPTH))
		else $error("fill count beyond depth");

	a_fill_only_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!apply_go |=> $stable(fill_q))
		else $error("fill count moved outside the update stage");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STAT_FULL) |-> (count_q == CW'(TOTAL_DEPTH)))
		else $error("full status with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STAT_EMPTY) |-> (count_q == '0 && popped_q == '0))
		else $error("empty status on a non-empty store");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_APPLY) |-> !(ld_q && rm_q))
		else $error("push and removal decoded together");

endmodule

[hw/rtl/segstk_cell.sv]
// One storage cell of the segmented stack: holds a single entry.
// Depends on segstk_pkg (cell_ctrl_t).
module segstk_cell
	import segstk_pkg::*;
#(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic [DATA_WIDTH-1:0] data_q,
	output logic [DATA_WIDTH-1:0] tap
);

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			data_q <= wr_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;  // close the gap left by a removal
		end
	end

	assign tap = ctrl.sel ? data_q : '0;

endmodule
